// ===== rtl/rdf_pkg.sv =====
// Package for the radix digit formatter: sizes, radix codes, the control
// struct handed to the digit cells and the ASCII mapping of one digit.
// No dependencies.
package rdf_pkg;

    localparam int VALUE_BITS = 32;
    localparam int IN_BITS    = 32;
    // Octal needs the most digits: one per three bits.
    localparam int N_DIGITS   = (VALUE_BITS + 2) / 3;
    localparam int CNT_W      = $clog2(VALUE_BITS + N_DIGITS);
    localparam int LEFT_W     = $clog2(N_DIGITS + 1);

    localparam logic [1:0] MODE_DEC  = 2'd0;
    localparam logic [1:0] MODE_OCT  = 2'd1;
    localparam logic [1:0] MODE_HEXL = 2'd2;
    localparam logic [1:0] MODE_HEXU = 2'd3;

    localparam logic [4:0] BASE_DEC = 5'd10;
    localparam logic [4:0] BASE_OCT = 5'd8;
    localparam logic [4:0] BASE_HEX = 5'd16;

    localparam logic [7:0] CHAR_ZERO        = 8'd48;
    localparam logic [7:0] LOWER_HEX_OFFSET = 8'd87;
    localparam logic [7:0] UPPER_HEX_OFFSET = 8'd55;

    typedef struct packed {
        logic       clr;
        logic       shift;
        logic [4:0] base;
    } t_cell_ctl;

    function automatic logic [4:0] mode_base(input logic [1:0] mode);
        logic [4:0] b;
        case (mode)
            MODE_DEC: b = BASE_DEC;
            MODE_OCT: b = BASE_OCT;
            default:  b = BASE_HEX;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] digit_ascii(input logic [3:0] d, input logic [1:0] mode);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = CHAR_ZERO + {4'd0, d};
        end else if (mode == MODE_HEXU) begin
            c = UPPER_HEX_OFFSET + {4'd0, d};
        end else begin
            c = LOWER_HEX_OFFSET + {4'd0, d};
        end
        return c;
    endfunction

endpackage

// ===== rtl/rdf_in_if.sv =====
// Input channel of the radix digit formatter: one number and its radix mode.
// Depends on rdf_pkg.
interface rdf_in_if
    import rdf_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [IN_BITS-1:0] value;
    logic [1:0]         radix_mode;

    modport source (output valid, output value, output radix_mode, input ready);
    modport sink   (input valid, input value, input radix_mode, output ready);
endinterface

// ===== rtl/rdf_out_if.sv =====
// Output channel of the radix digit formatter: one ASCII digit per transaction.
// No dependencies.
interface rdf_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  digit_char;
    logic        last_digit;
    logic [31:0] chars_total;

    modport source (output valid, output digit_char, output last_digit,
                    output chars_total, input ready);
    modport sink   (input valid, input digit_char, input last_digit,
                    input chars_total, output ready);
endinterface

// ===== rtl/rdf_cell.sv =====
// One digit cell of the conversion chain: doubles its digit and adds the
// carry from the cell below, reducing modulo the base. Depends on rdf_pkg.
module rdf_cell
    import rdf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctl  i_ctl,
    input  logic       i_carry,
    input  logic       i_carry_vld,
    input  logic [3:0] i_digit,
    output logic       o_carry,
    output logic       o_carry_vld,
    output logic [3:0] o_digit
);
    logic [3:0] r_digit, n_digit;
    logic       r_carry, n_carry;
    logic       r_vld, n_vld;
    logic [4:0] w_dbl;

    assign w_dbl = {r_digit, i_carry};

    always_comb begin
        n_digit = r_digit;
        n_carry = 1'b0;
        n_vld   = i_carry_vld;
        if (i_ctl.clr) begin
            n_digit = 4'd0;
            n_vld   = 1'b0;
        end else if (i_ctl.shift) begin
            // Digits move one place toward the most significant end.
            n_digit = i_digit;
        end else if (i_carry_vld) begin
            if (w_dbl >= i_ctl.base) begin
                n_digit = 4'(w_dbl - i_ctl.base);
                n_carry = 1'b1;
            end else begin
                n_digit = w_dbl[3:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= 1'b0;
            r_carry <= 1'b0;
        end else begin
            r_vld   <= n_vld;
            r_carry <= n_carry;
        end
        r_digit <= n_digit;
    end

    assign o_carry     = r_carry;
    assign o_carry_vld = r_vld;
    assign o_digit     = r_digit;
endmodule

// ===== rtl/radix_digit_formatter.sv =====
// Radix digit formatter top level: feeder shift register, digit cell chain
// and emit control. Depends on rdf_pkg, rdf_in_if, rdf_out_if and rdf_cell.
//
// Usage: an input transaction carries a 32-bit unsigned value and a radix
// mode (decimal, octal, lower-case or upper-case hex). The block answers with
// one output transaction per ASCII digit, most significant first, without
// leading zeros; zero gives a single '0'. The final digit has last_digit set,
// and chars_total counts every character emitted since reset, wrapping at 32
// bits.
// Operation: the value enters the cell chain one bit per cycle, most
// significant bit first, and the carry moves one cell per cycle. The
// chain then shifts out one leading zero per cycle and one digit per
// accepted output transaction. One number is handled at a time; ready is
// high only between numbers, so the block does not take a new number
// before the last digit of the current one has been accepted.
// A stalled receiver holds the current digit; the chain waits with it.
// Reset clears the character count and returns the block to idle.
module radix_digit_formatter
    import rdf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    rdf_in_if.sink    i_in,
    rdf_out_if.source o_out
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]            r_state, n_state;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [LEFT_W-1:0]     r_left, n_left;
    logic [VALUE_BITS-1:0] r_shift, n_shift;
    logic [1:0]            r_mode, n_mode;
    logic [31:0]           r_chars, n_chars;
    logic                  r_lead, n_lead;

    t_cell_ctl  w_ctl;
    logic       w_feed_vld;
    logic       w_skip;
    logic       w_out_acc;
    logic [3:0] w_top;

    logic       w_carry [N_DIGITS];
    logic       w_vld   [N_DIGITS];
    logic [3:0] w_digit [N_DIGITS];

    assign w_top      = w_digit[N_DIGITS-1];
    // Zeros are dropped only until the first digit has gone out.
    assign w_skip     = (r_state == ST_EMIT) && r_lead && (w_top == 4'd0)
                        && (r_left > LEFT_W'(1));
    assign w_out_acc  = o_out.valid && o_out.ready;
    assign w_feed_vld = (r_state == ST_CONV) && (r_cnt < CNT_W'(VALUE_BITS));

    assign i_in.ready        = (r_state == ST_IDLE);
    assign o_out.valid       = (r_state == ST_EMIT) && !w_skip;
    assign o_out.digit_char  = digit_ascii(w_top, r_mode);
    assign o_out.last_digit  = (r_left == LEFT_W'(1));
    assign o_out.chars_total = r_chars + 32'd1;

    always_comb begin
        w_ctl.clr   = i_in.valid && i_in.ready;
        w_ctl.shift = w_skip || w_out_acc;
        w_ctl.base  = mode_base(r_mode);
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_left  = r_left;
        n_shift = r_shift;
        n_mode  = r_mode;
        n_chars = r_chars;
        n_lead  = r_lead;
        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_shift = VALUE_BITS'(i_in.value);
                    n_mode  = i_in.radix_mode;
                    n_cnt   = '0;
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                n_shift = r_shift << 1;
                n_cnt   = r_cnt + CNT_W'(1);
                // The top cell takes its last carry this cycle.
                if (r_cnt == CNT_W'(VALUE_BITS + N_DIGITS - 2)) begin
                    n_left  = LEFT_W'(N_DIGITS);
                    n_lead  = 1'b1;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_skip || w_out_acc) begin
                    n_left = r_left - LEFT_W'(1);
                end
                if (w_out_acc) begin
                    n_chars = r_chars + 32'd1;
                    n_lead  = 1'b0;
                    if (r_left == LEFT_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_left  <= '0;
            r_chars <= '0;
            r_lead  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_left  <= n_left;
            r_chars <= n_chars;
            r_lead  <= n_lead;
        end
        r_shift <= n_shift;
        r_mode  <= n_mode;
    end

    for (genvar i = 0; i < N_DIGITS; i++) begin : g_cell
        if (i == 0) begin : g_first
            rdf_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (w_ctl),
                .i_carry     (r_shift[VALUE_BITS-1]),
                .i_carry_vld (w_feed_vld),
                .i_digit     (4'd0),
                .o_carry     (w_carry[i]),
                .o_carry_vld (w_vld[i]),
                .o_digit     (w_digit[i])
            );
        end else begin : g_next
            rdf_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (w_ctl),
                .i_carry     (w_carry[i-1]),
                .i_carry_vld (w_vld[i-1]),
                .i_digit     (w_digit[i-1]),
                .o_carry     (w_carry[i]),
                .o_carry_vld (w_vld[i]),
                .o_digit     (w_digit[i])
            );
        end
    end

    // A digit is only offered while emitting, with digits still left.
    a_out_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (r_state == ST_EMIT) && (r_left != '0))
        else $error("output valid outside of emit phase");

    // The final digit hands the block back to the input side.
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_out.last_digit) |=> i_in.ready)
        else $error("block not idle after the final digit");

    // Each accepted digit advances the character count by exactly one.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc |=> (r_chars == $past(r_chars) + 32'd1))
        else $error("character count did not advance");

    // The carry out of the top cell stays zero throughout conversion.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CONV) |-> !w_carry[N_DIGITS-1])
        else $error("digit chain overflowed");
endmodule
